[rtl/core/bnc_pkg.sv]
`default_nettype none

package bnc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int SYM_W     = 8;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W  = 2;
   localparam int SCORE_W   = 38;
   localparam int KIND_W    = 2;
   localparam int NUM_KINDS = 4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BALANCED   = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_CORRUPT    = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ERR_ROUND  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_SQUARE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_CURLY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_ANGLE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

   localparam logic [CSR_W-1:0] ERR_ROUND_RESET  = 16'd3;
   localparam logic [CSR_W-1:0] ERR_SQUARE_RESET = 16'd57;
   localparam logic [CSR_W-1:0] ERR_CURLY_RESET  = 16'd1197;
   localparam logic [CSR_W-1:0] ERR_ANGLE_RESET  = 16'd25137;

   localparam logic [SYM_W-1:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [SYM_W-1:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [SYM_W-1:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [SYM_W-1:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [SYM_W-1:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [SYM_W-1:0] CHAR_CURLY_CLOSE  = 8'h7D;
   localparam logic [SYM_W-1:0] CHAR_ANGLE_OPEN   = 8'h3C;
   localparam logic [SYM_W-1:0] CHAR_ANGLE_CLOSE  = 8'h3E;

   // classified word handed from front to back
   typedef struct packed {
      logic              eol;
      logic              opener;
      logic              closer;
      logic [KIND_W-1:0] kind;
   } word_type;

   function automatic word_type classify(input logic req_type, input logic [SYM_W-1:0] sym);
      word_type w;
      w = '0;
      w.eol = req_type;
      unique case (sym)
         CHAR_ROUND_OPEN: begin
            w.opener = 1'b1;
            w.kind   = KIND_ROUND;
         end
         CHAR_SQUARE_OPEN: begin
            w.opener = 1'b1;
            w.kind   = KIND_SQUARE;
         end
         CHAR_CURLY_OPEN: begin
            w.opener = 1'b1;
            w.kind   = KIND_CURLY;
         end
         CHAR_ANGLE_OPEN: begin
            w.opener = 1'b1;
            w.kind   = KIND_ANGLE;
         end
         CHAR_ROUND_CLOSE: begin
            w.closer = 1'b1;
            w.kind   = KIND_ROUND;
         end
         CHAR_SQUARE_CLOSE: begin
            w.closer = 1'b1;
            w.kind   = KIND_SQUARE;
         end
         CHAR_CURLY_CLOSE: begin
            w.closer = 1'b1;
            w.kind   = KIND_CURLY;
         end
         CHAR_ANGLE_CLOSE: begin
            w.closer = 1'b1;
            w.kind   = KIND_ANGLE;
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // value times 5**level, wrapping in 64 bits; elaboration-time only
   function automatic logic [63:0] weight(input int level, input int value);
      logic [63:0] p;
      p = 64'(value);
      for (int i = 0; i < level; i++) begin
         p = p * 64'd5;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/core/bnc_front.sv]
`default_nettype none

module bnc_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_type,
   input  wire logic [bnc_pkg::SYM_W-1:0]  req_symbol,
   output logic                            q_valid,
   input  wire logic                       q_pop,
   output bnc_pkg::word_type               q_word
);
   import bnc_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   word_type   word_ff [QUEUE_DEPTH];
   word_type   word_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign q_word    = word_ff[rd_ptr_ff];

   always_comb begin
      push      = req_valid && !req_stall;
      pop       = q_pop && q_valid;
      word_in   = classify(req_type, req_symbol);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff[wr_ptr_ff] <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/bnc_back.sv]
`default_nettype none

module bnc_back #(
   parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [bnc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bnc_pkg::CSR_W-1:0]     csr_wr_data,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   input  bnc_pkg::word_type                  q_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bnc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bnc_pkg::SCORE_W-1:0]        rsp_score
);
   import bnc_pkg::*;

   localparam int LVL_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // weight of a kind at a stack position: (kind + 1) * 5**position
   logic [SCORE_W-1:0] wt_tab [STACK_DEPTH][NUM_KINDS];

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_row
      for (genvar k = 0; k < NUM_KINDS; k++) begin : g_kind
         assign wt_tab[g][k] = SCORE_W'(weight(g, k + 1));
      end
   end

   logic [CSR_W-1:0]   err_ff [NUM_KINDS];
   logic [KIND_W-1:0]  stack_ff [STACK_DEPTH];
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               corrupt_ff, corrupt_in;
   logic               overflow_ff, overflow_in;
   logic [CSR_W-1:0]   cscore_ff, cscore_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic               take;
   logic               rsp_load;
   logic               stack_we;
   logic [LVL_W-1:0]   lvl_dec;
   logic [IDX_W-1:0]   push_idx;
   logic [IDX_W-1:0]   pop_idx;
   logic [KIND_W-1:0]  top;
   logic               full;
   logic               empty;
   logic [CSR_W-1:0]   hit_score;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_score  = rsp_score_ff;
   assign q_pop      = take;

   always_comb begin
      take      = q_valid && !(rsp_valid_ff && rsp_stall);
      lvl_dec   = level_ff - LVL_W'(1);
      push_idx  = level_ff[IDX_W-1:0];
      pop_idx   = lvl_dec[IDX_W-1:0];
      top       = stack_ff[pop_idx];
      full      = (level_ff >= LVL_W'(STACK_DEPTH));
      empty     = (level_ff == '0);
      hit_score = q_word.closer ? err_ff[q_word.kind] : '0;

      priority if (overflow_ff) begin
         rsp_status_in = STATUS_OVERFLOW;
         rsp_score_in  = '0;
      end else if (corrupt_ff) begin
         rsp_status_in = STATUS_CORRUPT;
         rsp_score_in  = SCORE_W'(cscore_ff);
      end else if (empty) begin
         rsp_status_in = STATUS_BALANCED;
         rsp_score_in  = '0;
      end else begin
         rsp_status_in = STATUS_INCOMPLETE;
         rsp_score_in  = score_ff;
      end

      level_in    = level_ff;
      corrupt_in  = corrupt_ff;
      overflow_in = overflow_ff;
      cscore_in   = cscore_ff;
      score_in    = score_ff;
      stack_we    = 1'b0;
      rsp_load    = 1'b0;

      if (take) begin
         if (q_word.eol) begin
            // report, then clear the line
            rsp_load    = 1'b1;
            level_in    = '0;
            corrupt_in  = 1'b0;
            overflow_in = 1'b0;
            cscore_in   = '0;
            score_in    = '0;
         end else if (!(corrupt_ff || overflow_ff)) begin
            if (q_word.opener) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  stack_we = 1'b1;
                  level_in = level_ff + LVL_W'(1);
                  score_in = score_ff + wt_tab[push_idx][q_word.kind];
               end
            end else if (empty) begin
               corrupt_in = 1'b1;
               cscore_in  = hit_score;
            end else begin
               level_in = lvl_dec;
               score_in = score_ff - wt_tab[pop_idx][top];
               if (!(q_word.closer && (q_word.kind == top))) begin
                  corrupt_in = 1'b1;
                  cscore_in  = hit_score;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ff[push_idx] <= q_word.kind;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_score_ff  <= rsp_score_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         corrupt_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         cscore_ff    <= '0;
         score_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff    <= level_in;
         corrupt_ff  <= corrupt_in;
         overflow_ff <= overflow_in;
         cscore_ff   <= cscore_in;
         score_ff    <= score_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff[KIND_ROUND]  <= ERR_ROUND_RESET;
         err_ff[KIND_SQUARE] <= ERR_SQUARE_RESET;
         err_ff[KIND_CURLY]  <= ERR_CURLY_RESET;
         err_ff[KIND_ANGLE]  <= ERR_ANGLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ERR_ROUND:  err_ff[KIND_ROUND]  <= csr_wr_data;
            CSR_ERR_SQUARE: err_ff[KIND_SQUARE] <= csr_wr_data;
            CSR_ERR_CURLY:  err_ff[KIND_CURLY]  <= csr_wr_data;
            CSR_ERR_ANGLE:  err_ff[KIND_ANGLE]  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/bracket_nesting_checker.sv]
// An end-of-line word passes the front queue, is taken by the back end and has its
// result registered onto rsp. Throughput: one word per cycle while no result waits on
// a stalled rsp; stack and running completion score settle in the cycle the back end
// takes a word. While a result waits on rsp the back end holds, so the two-word queue
// fills and req stalls. Reset clears the line state, the queue and rsp_valid and
// restores the default error scores; stack entries are not cleared and need no sweep.
`default_nettype none

module bracket_nesting_checker #(
   parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [bnc_pkg::SYM_W-1:0]     req_symbol,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bnc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bnc_pkg::SCORE_W-1:0]        rsp_score,
   input  wire logic                          csr_wr_en,
   input  wire logic [bnc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bnc_pkg::CSR_W-1:0]     csr_wr_data
);
   import bnc_pkg::*;

   logic     q_valid;
   logic     q_pop;
   word_type q_word;

   bnc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_symbol (req_symbol),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_word     (q_word)
   );

   bnc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_word      (q_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_score   (rsp_score)
   );

endmodule

`default_nettype wire

[rtl/core/bnc_checker.sv]
`default_nettype none

module bnc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [bnc_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [bnc_pkg::SCORE_W-1:0]   rsp_score
);
   import bnc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_score))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERFLOW || rsp_status == STATUS_BALANCED)
      |-> rsp_score == '0)
      else $error("overflow or balanced line with nonzero score");

   // corruption score comes from a 16-bit register
   a_corrupt_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CORRUPT |-> rsp_score[SCORE_W-1:CSR_W] == '0)
      else $error("corruption score wider than a register");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (.*);

`default_nettype wire
